[rtl/csvft_pkg.sv]
// shared types, codes and the per-character tokenizer step for the csv field tokenizer
`default_nettype none

package csvft_pkg;

    // result kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_FIELD = 2'd1;
    localparam logic [1:0] KIND_ROW   = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SEP   = 2'd0;
    localparam logic [1:0] CFG_QUOTE = 2'd1;
    localparam logic [1:0] CFG_BREAK = 2'd2;
    localparam logic [1:0] CFG_HDR   = 2'd3;

    localparam logic [7:0] SEP_RESET   = 8'd44;
    localparam logic [7:0] QUOTE_RESET = 8'd34;
    localparam logic [7:0] BREAK_RESET = 8'd10;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    // packet queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [7:0] sep;
        logic [7:0] quote;
        logic [7:0] brk;
        logic       hdr_en;
    } t_cfg;

    typedef struct packed {
        logic qo;   // quoting open
        logic qc;   // quoting closed
        logic qr;   // odd quote run
        logic sfr;  // still in first row
    } t_tok;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       hdr;
    } t_res;

    // up to three results caused by one word, packed in order
    typedef struct packed {
        logic [1:0]       cnt;
        t_res [2:0]       res;
    } t_pkt;

    typedef struct packed {
        t_tok st;
        logic emit;
        t_res res;
    } t_feed;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    localparam t_tok TOK_RESET = '{qo: 1'b0, qc: 1'b0, qr: 1'b0, sfr: 1'b1};

    function automatic t_feed feed(input t_tok st, input logic [7:0] c, input t_cfg cfg);
        t_feed f;
        f.st        = st;
        f.emit      = 1'b0;
        f.res.kind  = KIND_CHAR;
        f.res.data  = c;
        f.res.hdr   = cfg.hdr_en & st.sfr;
        if (c == cfg.quote) begin
            if (!st.qo) begin
                f.st.qo = 1'b1;
            end else if (st.qr) begin
                // second quote of a pair gives one quote character
                f.st.qr   = 1'b0;
                f.emit    = 1'b1;
                f.res.data = cfg.quote;
            end else begin
                f.st.qr = 1'b1;
            end
        end else begin
            if (st.qo && st.qr) begin
                f.st.qc = 1'b1;
            end
            f.st.qr = 1'b0;
            if (((c == cfg.sep) || (c == cfg.brk)) && (!f.st.qo || f.st.qc)) begin
                f.emit     = 1'b1;
                f.res.kind = (c == cfg.brk) ? KIND_ROW : KIND_FIELD;
                f.res.data = 8'd0;
                f.st.qo    = 1'b0;
                f.st.qc    = 1'b0;
                if (c == cfg.brk) begin
                    f.st.sfr = 1'b0;
                end
            end else begin
                f.emit = 1'b1;
            end
        end
        return f;
    endfunction

endpackage

`default_nettype wire

[rtl/csvft_front.sv]
// front end: accepts words, tracks quoting and line state, builds result packets
`default_nettype none

module csvft_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire [7:0]        i_byte,
    input  wire              i_end,
    input  wire              i_full,
    input  wire csvft_pkg::t_cfg i_cfg,
    output logic             o_stall,
    output logic             o_push,
    output csvft_pkg::t_pkt  o_pkt
);

    csvft_pkg::t_tok  r_st, n_st;
    logic             r_carr, n_carr;

    csvft_pkg::t_feed f1, f2;
    csvft_pkg::t_tok  st1, st2;
    csvft_pkg::t_pkt  pkt;
    logic [7:0]       c;
    logic             drop, lwb, accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        pkt    = '0;
        n_carr = r_carr;
        c      = i_byte;
        drop   = r_carr && (i_byte == csvft_pkg::CHAR_LF);
        f1     = '0;
        f2     = '0;
        st1    = r_st;
        st2    = r_st;
        lwb    = 1'b1;
        if (drop) begin
            // lf after cr is part of the line break already given
            n_carr = 1'b0;
        end else begin
            if (i_byte == csvft_pkg::CHAR_CR) begin
                c      = i_cfg.brk;
                n_carr = 1'b1;
            end else begin
                n_carr = 1'b0;
            end
            f1  = csvft_pkg::feed(r_st, c, i_cfg);
            st1 = f1.st;
            lwb = (c == i_cfg.brk);
            if (f1.emit) begin
                pkt.res[pkt.cnt] = f1.res;
                pkt.cnt          = pkt.cnt + 2'd1;
            end
        end
        st2 = st1;
        n_st = st1;
        if (i_end) begin
            if (!lwb) begin
                // supply the missing final line break
                f2  = csvft_pkg::feed(st1, i_cfg.brk, i_cfg);
                st2 = f2.st;
                if (f2.emit) begin
                    pkt.res[pkt.cnt] = f2.res;
                    pkt.cnt          = pkt.cnt + 2'd1;
                end
            end
            if (st2.qo && !st2.qc) begin
                pkt.res[pkt.cnt].kind = st2.qr ? csvft_pkg::KIND_ROW : csvft_pkg::KIND_ERR;
                pkt.res[pkt.cnt].data = 8'd0;
                pkt.res[pkt.cnt].hdr  = i_cfg.hdr_en & st2.sfr;
                pkt.cnt               = pkt.cnt + 2'd1;
            end
            n_st   = csvft_pkg::TOK_RESET;
            n_carr = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= csvft_pkg::TOK_RESET;
            r_carr <= 1'b0;
        end else if (accept) begin
            r_st   <= n_st;
            r_carr <= n_carr;
        end
    end

    assign o_push = accept && (pkt.cnt != 2'd0);
    assign o_pkt  = pkt;

endmodule

`default_nettype wire

[rtl/csvft_queue.sv]
// short packet queue between the front and back parts
`default_nettype none

module csvft_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  wire csvft_pkg::t_pkt i_pkt,
    input  wire                i_pop,
    output csvft_pkg::t_pkt    o_pkt,
    output csvft_pkg::t_qstat  o_stat
);

    csvft_pkg::t_pkt                    r_slot [csvft_pkg::QUEUE_DEPTH];
    logic [csvft_pkg::QPTR_W-1:0]       r_wr, r_rd;
    logic [csvft_pkg::QCNT_W-1:0]       r_cnt;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == csvft_pkg::QCNT_W'(csvft_pkg::QUEUE_DEPTH));
    assign o_pkt        = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/csvft_back.sv]
// back end: walks each packet and drives the registered result word
`default_nettype none

module csvft_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_q_valid,
    input  wire csvft_pkg::t_pkt i_pkt,
    output logic             o_pop,
    input  wire              i_out_stall,
    output logic             o_valid,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data,
    output logic             o_hdr,
    output logic             o_last
);

    logic            r_valid;
    csvft_pkg::t_res r_res;
    logic            r_last;
    logic [1:0]      r_sub;

    logic            load, last;

    assign load  = i_q_valid && (!r_valid || !i_out_stall);
    assign last  = (r_sub == (i_pkt.cnt - 2'd1));
    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= last ? 2'd0 : (r_sub + 2'd1);
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= i_pkt.res[r_sub];
            r_last <= last;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_res.kind;
    assign o_data  = r_res.data;
    assign o_hdr   = r_res.hdr;
    assign o_last  = r_last;

endmodule

`default_nettype wire

[rtl/csv_field_tokenizer_unit.sv]
// top level of the csv field tokenizer: configuration registers, front, queue and back
`default_nettype none

// Tokenizes a CSV text at one input word per clock while the queue is not full. Each
// accepted byte gives zero or one result; the byte flagged as end of text can give up to
// three (its own result, a supplied line break and an end-of-row or unclosed-quote marker),
// and the output side delivers one result per cycle unless stalled. A four-packet queue
// between the classifying front and the output back absorbs these bursts, so input accepts
// continue while earlier results wait. With nothing queued ahead, a byte's result is written
// to the queue, then to the back end's output register. The user must write configuration
// through the write port only while no word is in flight; the block does not enforce it.
module csv_field_tokenizer_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_idx,
    input  wire [7:0]  i_cfg_data,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire [7:0]  i_in_byte,
    input  wire        i_end_of_text,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_in_header,
    output logic       o_last_result
);

    csvft_pkg::t_cfg   r_cfg;
    csvft_pkg::t_pkt   push_pkt, head_pkt;
    csvft_pkg::t_qstat q_stat;
    logic              q_push, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sep    <= csvft_pkg::SEP_RESET;
            r_cfg.quote  <= csvft_pkg::QUOTE_RESET;
            r_cfg.brk    <= csvft_pkg::BREAK_RESET;
            r_cfg.hdr_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                csvft_pkg::CFG_SEP:   r_cfg.sep    <= i_cfg_data;
                csvft_pkg::CFG_QUOTE: r_cfg.quote  <= i_cfg_data;
                csvft_pkg::CFG_BREAK: r_cfg.brk    <= i_cfg_data;
                csvft_pkg::CFG_HDR:   r_cfg.hdr_en <= i_cfg_data[0];
                default:              r_cfg        <= r_cfg;
            endcase
        end
    end

    csvft_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_in_byte),
        .i_end   (i_end_of_text),
        .i_full  (q_stat.full),
        .i_cfg   (r_cfg),
        .o_stall (o_in_stall),
        .o_push  (q_push),
        .o_pkt   (push_pkt)
    );

    csvft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pkt   (push_pkt),
        .i_pop   (q_pop),
        .o_pkt   (head_pkt),
        .o_stat  (q_stat)
    );

    csvft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (!q_stat.empty),
        .i_pkt       (head_pkt),
        .o_pop       (q_pop),
        .i_out_stall (i_out_stall),
        .o_valid     (o_out_valid),
        .o_kind      (o_kind),
        .o_data      (o_out_byte),
        .o_hdr       (o_in_header),
        .o_last      (o_last_result)
    );

    // markers carry no character
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind != csvft_pkg::KIND_CHAR)) |-> (o_out_byte == 8'd0))
        else $error("marker word with nonzero byte");

    // an unclosed quote error always ends the word's results
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == csvft_pkg::KIND_ERR)) |-> o_last_result)
        else $error("error marker not last result");

    // back end only drains packets that exist
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

endmodule

`default_nettype wire
